// ===== src/msb_first_bit_packer_assert.svh =====
// Assertion helpers for the bit packer checker.
`ifndef MSB_FIRST_BIT_PACKER_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define PBK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define PBK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pbk_pkg.sv =====
package pbk_pkg;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 3;
  localparam int CODE_W      = 32;
  localparam int LEN_W       = 6;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } pbk_state_t;

  typedef enum logic {
    SH_APPEND,
    SH_EXTRACT
  } shift_op_t;

endpackage

// ===== src/pbk_shift_unit.sv =====
// Shared barrel shifter: appends a masked code at the bottom, or brings
// the byte at a given offset down to bit 0.
module pbk_shift_unit #(
  parameter int ACC_BITS = 64,
  parameter int AMT_W    = 7
) (
  input  pbk_pkg::shift_op_t         op,
  input  logic [ACC_BITS-1:0]        acc,
  input  logic [AMT_W-1:0]           amount,
  input  logic [pbk_pkg::CODE_W-1:0] code,
  output logic [ACC_BITS-1:0]        result
);

  logic [ACC_BITS-1:0] code_ext;
  logic [ACC_BITS-1:0] code_mask;

  assign code_ext  = ACC_BITS'(code);
  assign code_mask = ~({ACC_BITS{1'b1}} << amount);

  always_comb begin
    unique case (op)
      pbk_pkg::SH_APPEND:  result = (acc << amount) | (code_ext & code_mask);
      pbk_pkg::SH_EXTRACT: result = acc >> amount;
      default:             result = acc;
    endcase
  end

endmodule

// ===== src/msb_first_bit_packer.sv =====
// MSB-first variable-length bit packer.
// Input stream (s_*): tuser is the opcode (append or drain); tdata carries
// code_value in [31:0] and code_length in [37:32]. An append shifts the low
// code_length bits into an ACC_BITS-wide accumulator and returns one status
// request; bad lengths and codes that would overfill are rejected untouched.
// A drain returns every whole byte held, oldest first, tlast on the final
// one; with under eight bits held it returns a single request with no byte.
// Output stream (m_*): tdata is the byte, tuser = {status, byte_valid}.
// Timing: an append's result is registered at the accepting edge, so it
// shows in the following cycle. A drain first enters the drain sequencer,
// then returns one byte per cycle through the shared shifter while the
// output is not stalled by the receiver.
// Input is not taken while the sequencer drains or while an output request
// sits unclaimed; a stalled receiver simply holds the block in place.
// Reset clears the accumulator, the bit count and the output valid.
module msb_first_bit_packer #(
  parameter int ACC_BITS      = 64,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [31:0] code_value, [37:32] code_length, [39:38] zero
  input  logic [pbk_pkg::IN_TDATA_W-1:0]      s_tdata,
  // [0] opcode
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] out_byte
  output logic [pbk_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // [0] byte_valid, [2:1] status
  output logic [pbk_pkg::OUT_TUSER_W-1:0]     m_tuser,
  output logic                                m_tlast
);

  localparam int HW = $clog2(ACC_BITS + 1);
  localparam int LW = HW + 1;

  pbk_pkg::pbk_state_t state, state_next;
  logic [ACC_BITS-1:0] acc, acc_next;
  logic [HW-1:0]       held, held_next;

  logic                            m_tvalid_next;
  logic [pbk_pkg::OUT_TDATA_W-1:0] m_tdata_next;
  logic [pbk_pkg::OUT_TUSER_W-1:0] m_tuser_next;
  logic                            m_tlast_next;

  logic [pbk_pkg::CODE_W-1:0] code_value;
  logic [pbk_pkg::LEN_W-1:0]  code_length;
  logic                       out_free;
  logic [1:0]                 app_status;
  logic [LW-1:0]              free_bits;

  pbk_pkg::shift_op_t  sh_op;
  logic [HW-1:0]       sh_amount;
  logic [ACC_BITS-1:0] sh_result;

  assign code_value  = s_tdata[pbk_pkg::CODE_W-1:0];
  assign code_length = s_tdata[pbk_pkg::CODE_W +: pbk_pkg::LEN_W];
  assign out_free    = !m_tvalid || m_tready;
  assign s_tready    = (state == pbk_pkg::S_IDLE) && out_free;
  assign free_bits   = LW'(ACC_BITS) - LW'(held);

  always_comb begin
    if (code_length > pbk_pkg::LEN_W'(MAX_CODE_BITS)) begin
      app_status = pbk_pkg::STATUS_BAD_LEN;
    end else if (free_bits < LW'(code_length)) begin
      app_status = pbk_pkg::STATUS_OVERFLOW;
    end else begin
      app_status = pbk_pkg::STATUS_OK;
    end
  end

  // in drain the shifter brings the oldest whole byte down to bit 0
  assign sh_op     = (state == pbk_pkg::S_DRAIN) ? pbk_pkg::SH_EXTRACT : pbk_pkg::SH_APPEND;
  assign sh_amount = (state == pbk_pkg::S_DRAIN) ? (held - HW'(8)) : HW'(code_length);

  pbk_shift_unit #(
    .ACC_BITS (ACC_BITS),
    .AMT_W    (HW)
  ) u_shift (
    .op     (sh_op),
    .acc    (acc),
    .amount (sh_amount),
    .code   (code_value),
    .result (sh_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pbk_pkg::S_IDLE;
      acc      <= '0;
      held     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      acc      <= acc_next;
      held     <= held_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
    m_tlast <= m_tlast_next;
  end

  always_comb begin
    state_next    = state;
    acc_next      = acc;
    held_next     = held;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next  = m_tdata;
    m_tuser_next  = m_tuser;
    m_tlast_next  = m_tlast;

    unique case (state)
      pbk_pkg::S_IDLE: begin
        if (s_tvalid && s_tready) begin
          if (s_tuser == pbk_pkg::OP_APPEND) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tuser_next  = {app_status, 1'b0};
            m_tlast_next  = 1'b1;
            if (app_status == pbk_pkg::STATUS_OK) begin
              acc_next  = sh_result;
              held_next = held + HW'(code_length);
            end
          end else if (held < HW'(8)) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tuser_next  = {pbk_pkg::STATUS_OK, 1'b0};
            m_tlast_next  = 1'b1;
          end else begin
            state_next = pbk_pkg::S_DRAIN;
          end
        end
      end
      pbk_pkg::S_DRAIN: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = sh_result[pbk_pkg::OUT_TDATA_W-1:0];
          m_tuser_next  = {pbk_pkg::STATUS_OK, 1'b1};
          m_tlast_next  = held < HW'(16);
          held_next     = held - HW'(8);
          if (held < HW'(16)) begin
            state_next = pbk_pkg::S_IDLE;
          end
        end
      end
      default: state_next = pbk_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== src/pbk_checker.sv =====
`include "msb_first_bit_packer_assert.svh"

module pbk_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pbk_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [pbk_pkg::OUT_TUSER_W-1:0] m_tuser,
  input logic                            m_tlast
);

  logic byte_flag;
  logic rejected;
  logic [pbk_pkg::OUT_TDATA_W+pbk_pkg::OUT_TUSER_W:0] out_word;

  assign byte_flag = m_tuser[0];
  assign rejected  = m_tuser[2:1] != pbk_pkg::STATUS_OK;
  assign out_word  = {m_tdata, m_tuser, m_tlast};

  // input only taken when the output register can accept the result
  `PBK_ASSERT_NOW(a_ready_needs_room, s_tready, !m_tvalid || m_tready, "ready with output blocked")

  // a request without a byte always ends its item
  `PBK_ASSERT_NOW(a_nobyte_is_last, m_tvalid && !byte_flag, m_tlast, "byteless request not last")

  // a rejection carries no byte
  `PBK_ASSERT_NOW(a_reject_clean, m_tvalid && rejected, !byte_flag && m_tdata == '0 && m_tlast, "reject has data")

  `PBK_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(out_word), "stall changed output")

  // nothing is left pending right out of reset
  `PBK_ASSERT_NOW(a_reset_idle, $past(rst), !m_tvalid, "output valid after reset")

endmodule

bind msb_first_bit_packer pbk_checker u_pbk_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== test/msb_first_bit_packer_tb.sv =====
module msb_first_bit_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACC_W       = 64;
  localparam int MAX_CODE    = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_ITEMS  = 200;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [1:0] status;
    logic       last;
  } pack_result_t;

  typedef struct packed {
    logic                       op;
    logic [pbk_pkg::CODE_W-1:0] code;
    logic [pbk_pkg::LEN_W-1:0]  len;
    logic                       typed;
    pack_result_t               result;
  } stim_row_t;

  logic                            clk;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [pbk_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                            s_tuser  = pbk_pkg::OP_APPEND;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [pbk_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [pbk_pkg::OUT_TUSER_W-1:0] m_tuser;
  logic                            m_tlast;

  logic [ACC_W-1:0] acc_bits;
  int               acc_count;
  pack_result_t     pending_results[$];
  stim_row_t        directed_rows[$];
  int               errors;
  int               idle_cycles;
  int               send_idle_pct;
  int               ready_stall_pct;

  msb_first_bit_packer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic pack_result_t no_byte(input logic [1:0] status);
    return '{data: 8'h00, valid: 1'b0, status: status, last: 1'b1};
  endfunction

  // Expected results of one request; updates the packer state.
  task automatic pack_and_drain(input logic op, input logic [pbk_pkg::CODE_W-1:0] code,
                                input logic [pbk_pkg::LEN_W-1:0] len);
    int nbytes;
    if (op == pbk_pkg::OP_APPEND) begin
      if (len > MAX_CODE) begin
        pending_results.push_back(no_byte(pbk_pkg::STATUS_BAD_LEN));
      end else if (ACC_W - acc_count < int'(len)) begin
        pending_results.push_back(no_byte(pbk_pkg::STATUS_OVERFLOW));
      end else begin
        acc_bits  = (acc_bits << len) | (64'(code) & ((64'd1 << len) - 64'd1));
        acc_count = acc_count + len;
        pending_results.push_back(no_byte(pbk_pkg::STATUS_OK));
      end
    end else if (acc_count < 8) begin
      pending_results.push_back(no_byte(pbk_pkg::STATUS_OK));
    end else begin
      nbytes = acc_count / 8;
      for (int k = 0; k < nbytes; k++) begin
        pending_results.push_back('{data: 8'(acc_bits >> (acc_count - 8)), valid: 1'b1,
                                    status: pbk_pkg::STATUS_OK, last: (k == nbytes - 1)});
        acc_count = acc_count - 8;
      end
    end
  endtask

  // Drive one request, idling first at random; called at a rising edge.
  task automatic send_request(input stim_row_t row);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      if (!lowered) s_tvalid <= 1'b0;
      lowered = 1'b1;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= row.op;
    s_tdata  <= {2'b00, row.len, row.code};
    do @(posedge clk); while (!s_tready);
    pack_and_drain(row.op, row.code, row.len);
    if (row.typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(row.result);
    end
  endtask

  task automatic add_row(input logic op, input logic [pbk_pkg::CODE_W-1:0] code,
                         input logic [pbk_pkg::LEN_W-1:0] len, input logic typed,
                         input pack_result_t result);
    directed_rows.push_back('{op: op, code: code, len: len, typed: typed, result: result});
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  // Output check and watchdog
  always @(posedge clk) begin : check_out
    pack_result_t got;
    pack_result_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("msb_first_bit_packer verification failed");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        got = '{data: m_tdata, valid: m_tuser[0], status: m_tuser[2:1], last: m_tlast};
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected request byte %h valid %b status %0d last %b",
                   $realtime, got.data, got.valid, got.status, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: expected byte %h valid %b status %0d last %b,",
                     $realtime, want.data, want.valid, want.status, want.last,
                     " got byte %h valid %b status %0d last %b",
                     got.data, got.valid, got.status, got.last);
          end
        end
      end
    end
  end

  initial begin
    stim_row_t    row;
    pack_result_t none;
    int           pick;
    none            = '0;
    errors          = 0;
    acc_bits        = '0;
    acc_count       = 0;
    send_idle_pct   = 0;
    ready_stall_pct = 0;

    add_row(pbk_pkg::OP_DRAIN,  32'h0,        6'd0,  1'b1, no_byte(pbk_pkg::STATUS_OK));
    add_row(pbk_pkg::OP_APPEND, 32'hFFFFFFFF, 6'd63, 1'b1, no_byte(pbk_pkg::STATUS_BAD_LEN));
    add_row(pbk_pkg::OP_APPEND, 32'h00000001, 6'd33, 1'b1, no_byte(pbk_pkg::STATUS_BAD_LEN));
    add_row(pbk_pkg::OP_APPEND, 32'hFFFFFFFF, 6'd0,  1'b1, no_byte(pbk_pkg::STATUS_OK));
    add_row(pbk_pkg::OP_APPEND, 32'hFFFFFFFF, 6'd32, 1'b1, no_byte(pbk_pkg::STATUS_OK));
    add_row(pbk_pkg::OP_APPEND, 32'h12345678, 6'd32, 1'b1, no_byte(pbk_pkg::STATUS_OK));
    // accumulator is full now
    add_row(pbk_pkg::OP_APPEND, 32'h00000001, 6'd1,  1'b1, no_byte(pbk_pkg::STATUS_OVERFLOW));
    add_row(pbk_pkg::OP_DRAIN,  32'h0,        6'd0,  1'b0, none);
    add_row(pbk_pkg::OP_DRAIN,  32'hFFFFFFFF, 6'd63, 1'b1, no_byte(pbk_pkg::STATUS_OK));
    add_row(pbk_pkg::OP_APPEND, 32'hFFFFFFFD, 6'd3,  1'b0, none);
    add_row(pbk_pkg::OP_APPEND, 32'h0000007F, 6'd7,  1'b0, none);
    add_row(pbk_pkg::OP_DRAIN,  32'h0,        6'd0,  1'b0, none);
    add_row(pbk_pkg::OP_APPEND, 32'hAAAAAAAA, 6'd30, 1'b0, none);
    add_row(pbk_pkg::OP_APPEND, 32'h80000001, 6'd32, 1'b0, none);
    add_row(pbk_pkg::OP_APPEND, 32'h00000000, 6'd32, 1'b1, no_byte(pbk_pkg::STATUS_OVERFLOW));
    add_row(pbk_pkg::OP_DRAIN,  32'h0,        6'd0,  1'b0, none);
    add_row(pbk_pkg::OP_APPEND, 32'h00000000, 6'd32, 1'b0, none);
    add_row(pbk_pkg::OP_APPEND, 32'h0000C3A5, 6'd16, 1'b0, none);
    add_row(pbk_pkg::OP_APPEND, 32'hFFFF5A3C, 6'd16, 1'b0, none);
    add_row(pbk_pkg::OP_DRAIN,  32'h0,        6'd0,  1'b0, none);
    add_row(pbk_pkg::OP_DRAIN,  32'h0,        6'd0,  1'b0, none);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      case (n / (RAND_ITEMS / 4))
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 69; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 69; end
        default: begin send_idle_pct = 14; ready_stall_pct = 14; end
      endcase
      row  = '0;
      pick = $urandom_range(0, 99);
      row.code = $urandom;
      if (pick < 25) begin
        row.op = pbk_pkg::OP_DRAIN;
      end else if (pick < 32) begin
        row.op  = pbk_pkg::OP_APPEND;
        row.len = 6'($urandom_range(MAX_CODE + 1, 63));
      end else begin
        row.op = pbk_pkg::OP_APPEND;
        case ($urandom_range(0, 9))
          0:       row.len = 6'(MAX_CODE);
          1:       row.len = 6'd0;
          default: row.len = 6'($urandom_range(1, MAX_CODE));
        endcase
      end
      send_request(row);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("msb_first_bit_packer verification clean");
    end else begin
      $display("msb_first_bit_packer verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/pbk_pkg.sv
src/pbk_shift_unit.sv
src/msb_first_bit_packer.sv
src/pbk_checker.sv
test/msb_first_bit_packer_tb.sv
